FILE: src/double_clap_detector_core_defines.svh
// ----------------------------------------------------------------------------
// double_clap_detector_core_defines.svh
// Assertion macros for the checker file of the clap detector.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_CLAP_DETECTOR_CORE_DEFINES_SVH
`define DOUBLE_CLAP_DETECTOR_CORE_DEFINES_SVH

// Clocked on i_clk, quiet while i_rst_n is low.
`define DCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked on i_clk, checked during reset too.
`define DCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Types, constants and helpers of the double clap detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int SAMPLE_SHIFT = 16;
    localparam int AMP_W        = 16;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd10000;
    localparam logic [CFG_W-1:0] COOLDOWN_RST  = 16'd200;
    localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd1000;

    // one registered input beat, amplitude already extracted
    typedef struct packed {
        logic [AMP_W-1:0]  amp;
        logic              last;
        logic [TIME_W-1:0] now_ms;
    } t_beat;

    typedef struct packed {
        logic             clap;
        logic             double_clap;
        logic             pending;
        logic [AMP_W-1:0] peak;
    } t_result;

    // |top 16 bits|; 0x8000 maps to 32768, which still fits 16 bits
    function automatic logic [AMP_W-1:0] amplitude_of(input logic [SAMPLE_W-1:0] raw);
        logic [AMP_W-1:0] top;
        top = raw[SAMPLE_SHIFT +: AMP_W];
        return top[AMP_W-1] ? AMP_W'(~top + 1'b1) : top;
    endfunction

endpackage

FILE: src/dcd_block_stats.sv
// ----------------------------------------------------------------------------
// dcd_block_stats
// Running peak and loud flag over one block of samples.
// ----------------------------------------------------------------------------
module dcd_block_stats (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dcd_pkg::t_beat             i_beat,
    input  logic                       i_step,
    input  logic [dcd_pkg::CFG_W-1:0]  i_threshold,
    output logic [dcd_pkg::AMP_W-1:0]  o_peak,
    output logic                       o_loud
);
    import dcd_pkg::*;

    logic [AMP_W-1:0] r_peak, n_peak;
    logic             r_loud, n_loud;

    // figures including the beat now in the stage
    assign o_peak = (i_beat.amp > r_peak) ? i_beat.amp : r_peak;
    assign o_loud = r_loud | (i_beat.amp > i_threshold);

    always_comb begin
        n_peak = r_peak;
        n_loud = r_loud;
        if (i_step) begin
            n_peak = i_beat.last ? '0 : o_peak;
            n_loud = i_beat.last ? 1'b0 : o_loud;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_loud <= 1'b0;
        end else begin
            r_peak <= n_peak;
            r_loud <= n_loud;
        end
    end

endmodule

FILE: src/double_clap_detector_core.sv
// ----------------------------------------------------------------------------
// double_clap_detector_core
// Block-wise clap decision with cooldown and double clap window.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | beat
//  ----------+-------------------------------------------+-------------------
//  in        | i_in_valid / o_in_ready, sample, last, ms | one mic sample
//  out       | o_out_valid / i_out_ready, flags, peak    | one per block
//  cfg       | i_cfg_we, i_cfg_idx, i_cfg_data           | register write
//
//  One sample per cycle sustained while no block end waits on a held output. An
//  accepted beat is registered in the input stage, a block end's result in the output register.
//  Reset (synchronous, active low) restores the register defaults and clears
//  block stats, clap time and pending count. A held output only stalls the
//  input stage when the beat there closes a block; other samples flow on.
// ----------------------------------------------------------------------------
module double_clap_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_sample,
    input  logic                          i_last_in_block,
    input  logic [dcd_pkg::TIME_W-1:0]    i_now_ms,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [dcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dcd_pkg::CFG_W-1:0]     i_cfg_data,
    // block result
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_clap,
    output logic                          o_double_clap,
    output logic                          o_pending_claps,
    output logic [dcd_pkg::AMP_W-1:0]     o_peak_level
);
    import dcd_pkg::*;

    // configuration
    logic [CFG_W-1:0]  r_threshold, r_cooldown, r_window;

    // input stage
    t_beat             r_beat;
    logic              r_beat_vld;
    logic              step;

    // clap history: time of the last clap and the pending flag
    logic [TIME_W-1:0] r_clap_time;
    logic              r_pending, n_pending;

    // block stats incl. current beat
    logic [AMP_W-1:0]  peak;
    logic              loud;

    // decision
    logic [TIME_W-1:0] since_clap;
    logic              clap, dbl;

    // output register
    t_result           r_res, n_res;
    logic              r_out_vld;

    // ---- config port -------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_cooldown  <= COOLDOWN_RST;
            r_window    <= WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_COOLDOWN:  r_cooldown  <= i_cfg_data;
                CFG_WINDOW:    r_window    <= i_cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // ---- handshake ---------------------------------------------------------
    // A mid-block beat never needs the output slot; a block end needs it free
    // or leaving this cycle.
    assign step       = r_beat_vld && (!r_beat.last || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_beat_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_beat_vld <= i_in_valid;
        end
    end

    // amplitude is taken on the way into the stage
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat.amp    <= amplitude_of(i_sample);
            r_beat.last   <= i_last_in_block;
            r_beat.now_ms <= i_now_ms;
        end
    end

    // ---- block stats -------------------------------------------------------
    dcd_block_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (r_beat),
        .i_step      (step),
        .i_threshold (r_threshold),
        .o_peak      (peak),
        .o_loud      (loud)
    );

    // ---- clap decision -----------------------------------------------------
    // Time differences wrap mod 2^32; the 16-bit limits zero-extend.
    assign since_clap = r_beat.now_ms - r_clap_time;
    assign clap       = loud && (since_clap > TIME_W'(r_cooldown));
    assign dbl        = clap && r_pending && (since_clap < TIME_W'(r_window));

    // second clap in the window reports and clears; any other clap arms
    assign n_pending  = clap ? !dbl : r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clap_time <= '0;
            r_pending   <= 1'b0;
        end else if (step && r_beat.last) begin
            r_pending <= n_pending;
            if (clap) begin
                r_clap_time <= r_beat.now_ms;
            end
        end
    end

    // ---- output register ---------------------------------------------------
    always_comb begin
        n_res.clap        = clap;
        n_res.double_clap = dbl;
        n_res.pending     = n_pending;
        n_res.peak        = peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && r_beat.last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_beat.last) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_clap          = r_res.clap;
    assign o_double_clap   = r_res.double_clap;
    assign o_pending_claps = r_res.pending;
    assign o_peak_level    = r_res.peak;

endmodule

FILE: src/dcd_checker.sv
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks on the clap detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_clap_detector_core_defines.svh"

module dcd_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic                      o_clap,
    input  logic                      o_double_clap,
    input  logic                      o_pending_claps,
    input  logic [dcd_pkg::AMP_W-1:0] o_peak_level
);
    import dcd_pkg::*;

    logic [AMP_W+2:0] res_bits;     // whole result beat
    logic             out_stalled;  // result waiting on the receiver
    logic             out_dbl;      // double clap on a valid beat
    logic             out_single;   // single clap on a valid beat

    assign res_bits    = {o_clap, o_double_clap, o_pending_claps, o_peak_level};
    assign out_stalled = o_out_valid && !i_out_ready;
    assign out_dbl     = o_out_valid && o_double_clap;
    assign out_single  = o_out_valid && o_clap && !o_double_clap;

    // stalled result beat holds
    `DCD_ASSERT(a_out_hold, out_stalled |=> o_out_valid && $stable(res_bits), "stalled beat moved")

    // double clap only on a clap
    `DCD_ASSERT(a_dbl_is_clap, out_dbl |-> o_clap, "double clap without clap")

    // double clap empties the count, a lone clap arms it
    `DCD_ASSERT(a_dbl_clears, out_dbl |-> !o_pending_claps, "double clap left pending")
    `DCD_ASSERT(a_single_arms, out_single |-> o_pending_claps, "single clap not pending")

    // amplitude of a 16-bit value never exceeds 32768
    `DCD_ASSERT(a_peak_range, o_out_valid |-> o_peak_level <= 16'h8000, "peak out of range")

endmodule

bind double_clap_detector_core dcd_checker u_dcd_checker (.*);
